// File: src/i2r_pkg.sv
`default_nettype none
package i2r_pkg;

  localparam int unsigned NumW    = 12;
  localparam int unsigned CharW   = 7;
  localparam int unsigned IdxW    = 4;
  localparam logic [NumW-1:0] MAX_NUMBER = 12'd3999;

  localparam logic [CharW-1:0] CH_NONE = 7'h00;
  localparam logic [CharW-1:0] CH_I    = 7'h49;
  localparam logic [CharW-1:0] CH_V    = 7'h56;
  localparam logic [CharW-1:0] CH_X    = 7'h58;
  localparam logic [CharW-1:0] CH_L    = 7'h4C;
  localparam logic [CharW-1:0] CH_C    = 7'h43;
  localparam logic [CharW-1:0] CH_D    = 7'h44;
  localparam logic [CharW-1:0] CH_M    = 7'h4D;

  typedef logic [1:0] step_t;
  localparam step_t STEP_FETCH = 2'd0;
  localparam step_t STEP_SCAN  = 2'd1;
  localparam step_t STEP_PAIR  = 2'd2;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_ACCEPT,
    JC_PAIR
  } jcond_t;

  typedef struct packed {
    logic   take_in;
    logic   scan;
    logic   emit2;
    logic   end_ok;
    jcond_t cond;
    step_t  target;
  } cw_t;

  typedef struct packed {
    logic hold;
    logic taken;
    logic finish;
  } dp_stat_t;

  function automatic logic [NumW-1:0] sym_value(input logic [IdxW-1:0] idx);
    logic [NumW-1:0] v;
    unique case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CharW-1:0] sym_first(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd0:    c = CH_M;
      4'd1:    c = CH_C;
      4'd2:    c = CH_D;
      4'd3:    c = CH_C;
      4'd4:    c = CH_C;
      4'd5:    c = CH_X;
      4'd6:    c = CH_L;
      4'd7:    c = CH_X;
      4'd8:    c = CH_X;
      4'd9:    c = CH_I;
      4'd10:   c = CH_V;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] sym_second(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/i2r_ucode_rom.sv
`default_nettype none
module i2r_ucode_rom (
  input  i2r_pkg::step_t step,
  output i2r_pkg::cw_t   cw
);
  import i2r_pkg::*;

  always_comb begin
    unique case (step)
      STEP_FETCH: cw = '{take_in: 1'b1, scan: 1'b0, emit2: 1'b0, end_ok: 1'b0,
                         cond: JC_ACCEPT, target: STEP_SCAN};
      STEP_SCAN:  cw = '{take_in: 1'b0, scan: 1'b1, emit2: 1'b0, end_ok: 1'b1,
                         cond: JC_PAIR, target: STEP_PAIR};
      STEP_PAIR:  cw = '{take_in: 1'b0, scan: 1'b0, emit2: 1'b1, end_ok: 1'b1,
                         cond: JC_ALWAYS, target: STEP_SCAN};
      default:    cw = '{take_in: 1'b0, scan: 1'b0, emit2: 1'b0, end_ok: 1'b0,
                         cond: JC_ALWAYS, target: STEP_FETCH};
    endcase
  end

endmodule
`default_nettype wire

// File: src/i2r_datapath.sv
`default_nettype none
module i2r_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i2r_pkg::cw_t                  cw,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2r_pkg::NumW-1:0]      in_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i2r_pkg::CharW-1:0]     out_char_code,
  output logic                          out_last,
  output i2r_pkg::dp_stat_t             stat
);
  import i2r_pkg::*;

  logic [NumW-1:0]  rest_r, rest_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CharW-1:0] char_r, char_nxt;
  logic             last_r, last_nxt;

  logic [NumW-1:0]  sym_val;
  logic [NumW-1:0]  rest_sub;
  logic             fits, has2, num_ok, slot_free;
  logic             emit_first, emit_sec, emit, last_letter;

  assign in_ready      = cw.take_in;
  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

  always_comb begin
    sym_val    = sym_value(idx_r);
    fits       = (sym_val <= rest_r);
    rest_sub   = rest_r - sym_val;
    has2       = (sym_second(idx_r) != CH_NONE);
    num_ok     = (in_number != '0) && (in_number <= MAX_NUMBER);
    slot_free  = !out_valid_r || out_ready;
    emit_first = cw.scan && fits;
    emit_sec   = cw.emit2;
    emit       = emit_first || emit_sec;

    if (emit_first) begin
      last_letter = (rest_sub == '0) && !has2;
    end else if (emit_sec) begin
      last_letter = (rest_r == '0);
    end else begin
      last_letter = 1'b0;
    end

    stat.hold   = emit && !slot_free;
    stat.finish = cw.end_ok && last_letter;
    unique case (cw.cond)
      JC_ALWAYS: stat.taken = 1'b1;
      JC_ACCEPT: stat.taken = in_valid && num_ok;
      JC_PAIR:   stat.taken = emit_first && has2;
      default:   stat.taken = 1'b0;
    endcase

    rest_nxt      = rest_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;

    if (cw.take_in && in_valid) begin
      rest_nxt = in_number;
      idx_nxt  = '0;
    end else if (cw.scan && !stat.hold) begin
      if (fits) begin
        rest_nxt = rest_sub;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end

    if (slot_free) begin
      out_valid_nxt = emit;
      char_nxt      = emit_sec ? sym_second(idx_r) : sym_first(idx_r);
      last_nxt      = last_letter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire

// File: src/int_to_roman_encoder_unit.sv
// The fetch step takes the input; the scan step then skips the symbols above the remaining
//   value and registers each letter into the output slot that drives out_valid.
// A new number is taken only after the last letter of a numeral is registered. Unless the
//   output stalls, scan emits one letter or skips one symbol per cycle and pair emits the
//   second letter of a pair. Zero and values above 3999 are consumed in fetch, no beat.
// Reset: rst_n synchronous, active low; clears the step counter and output valid.
`default_nettype none
module int_to_roman_encoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [i2r_pkg::NumW-1:0]  in_number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [i2r_pkg::CharW-1:0] out_char_code,
  output logic                      out_last
);
  import i2r_pkg::*;

  step_t    step_r, step_nxt;
  cw_t      cw;
  dp_stat_t stat;

  i2r_ucode_rom u_rom (
    .step (step_r),
    .cw   (cw)
  );

  i2r_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cw            (cw),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .stat          (stat)
  );

  always_comb begin
    if (stat.hold) begin
      step_nxt = step_r;
    end else if (stat.finish) begin
      step_nxt = STEP_FETCH;
    end else if (stat.taken) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/i2r_checker.sv
`default_nettype none
module i2r_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [i2r_pkg::NumW-1:0]  in_number,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [i2r_pkg::CharW-1:0] out_char_code,
  input logic                      out_last
);
  import i2r_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("stalled output beat changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_number != '0) && (in_number <= MAX_NUMBER) |=> !in_ready)
    else $error("input taken while a numeral is in progress");

  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CH_I) || (out_char_code == CH_V) ||
                  (out_char_code == CH_X) || (out_char_code == CH_L) ||
                  (out_char_code == CH_C) || (out_char_code == CH_D) ||
                  (out_char_code == CH_M))
    else $error("output beat is not a numeral letter");

  a_mid_numeral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("ready for input before numeral ended");

endmodule

bind int_to_roman_encoder_unit i2r_checker u_i2r_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_number     (in_number),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);
`default_nettype wire

// File: tb/tb_int_to_roman_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_int_to_roman_encoder_unit;
  import i2r_pkg::*;

  localparam int DIR_N       = 25;
  localparam int RAND_ITEMS  = 285;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } letter_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [NumW-1:0]  in_number;
  logic             out_valid;
  logic             out_ready;
  logic [CharW-1:0] out_char_code;
  logic             out_last;

  letter_t staged_q[$];
  letter_t letters_q[$];
  int      errors = 0;
  int      cycles = 0;
  bit      burst;
  bit      long_hold_req;

  logic [NumW-1:0] dir_num [DIR_N];
  bit              dir_typed [DIR_N];
  string           dir_txt [DIR_N];

  int_to_roman_encoder_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(input bit no_idle);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (no_idle || r < 65) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic string roman_digit(input int unsigned d, input string one,
                                        input string five, input string ten);
    string r;
    int    k;
    if (d == 4) return {one, five};
    if (d == 9) return {one, ten};
    r = (d >= 5) ? five : "";
    for (k = 0; k < d % 5; k++) r = {r, one};
    return r;
  endfunction

  // decimal digit expansion; matches greedy subtractive encoding
  function automatic string roman_text(input logic [NumW-1:0] num);
    string       s;
    int unsigned v;
    int          k;
    s = "";
    v = num;
    if (v == 0 || v > MAX_NUMBER) return s;
    for (k = 0; k < v / 1000; k++) s = {s, "M"};
    v = v % 1000;
    s = {s, roman_digit(v / 100, "C", "D", "M")};
    s = {s, roman_digit((v / 10) % 10, "X", "L", "C")};
    s = {s, roman_digit(v % 10, "I", "V", "X")};
    return s;
  endfunction

  function automatic logic [NumW-1:0] pick_number();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(99, 0);
    if (r < 5) return '0;
    if (r < 10) return NumW'($urandom_range(4095, 4000));
    if (r < 30) return NumW'($urandom_range(60, 1));
    if (r < 50) begin
      // digit-heavy values: long numerals
      v = $urandom_range(3, 0) * 1000 + $urandom_range(9, 0) * 100
        + $urandom_range(9, 0) * 10 + $urandom_range(9, 0);
      return (v == 0) ? 12'd3888 : v[NumW-1:0];
    end
    return NumW'($urandom_range(3999, 1));
  endfunction

  task automatic stage_letters(input string s);
    letter_t l;
    byte     b;
    int      i;
    for (i = 0; i < s.len(); i++) begin
      b      = s.getc(i);
      l.code = b[CharW-1:0];
      l.last = (i == s.len() - 1);
      staged_q.push_back(l);
    end
  endtask

  task automatic send_number(input logic [NumW-1:0] num, input bit typed, input string txt);
    int gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stage_letters(typed ? txt : roman_text(num));
    in_valid  <= 1'b1;
    in_number <= num;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_letters
    letter_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        foreach (staged_q[i]) letters_q.push_back(staged_q[i]);
        staged_q.delete();
      end
      if (out_valid && out_ready) begin
        if (letters_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual %c last=%b",
                   $realtime, out_char_code, out_last);
          errors++;
        end else begin
          want = letters_q.pop_front();
          if (want.code !== out_char_code || want.last !== out_last) begin
            $display("%0t: mismatch: expected %c last=%b, actual %c (%h) last=%b",
                     $realtime, want.code, want.last, out_char_code, out_char_code,
                     out_last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d letters pending", $realtime, letters_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side
  initial begin
    int stall_left;
    int run_left;
    bit hold_done;
    stall_left = 0;
    run_left   = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(40, 0);
          stall_left = pick_gap(1'b0);
        end
      end
    end
  end

  // input side
  initial begin
    int              i;
    int              sent;
    logic [NumW-1:0] n;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_number     = '0;
    burst         = 1'b0;
    long_hold_req = 1'b0;

    dir_num   = '{12'd0, 12'd1, 12'd3999, 12'd3888, 12'd4000, 12'd4095, 12'd4, 12'd9,
                  12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
                  12'd2, 12'd3, 12'd14, 12'd49, 12'd944, 12'd1994, 12'd2048, 12'd2047,
                  12'd3000};
    dir_typed = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_txt   = '{"", "I", "MMMCMXCIX", "MMMDCCCLXXXVIII", "", "",
                  "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", ""};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_N; i++) send_number(dir_num[i], dir_typed[i], dir_txt[i]);

    // long receiver hold-off with back-to-back offers to fill the block, then random bursts
    burst         = 1'b1;
    long_hold_req = 1'b1;
    sent          = 0;
    i             = 0;
    while (sent < RAND_ITEMS) begin
      if (i % 32 == 31) burst = ($urandom_range(3, 0) == 0);
      n = pick_number();
      send_number(n, 1'b0, "");
      sent++;
      i++;
    end
    in_valid <= 1'b0;

    while (letters_q.size() != 0 || staged_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && letters_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
